>>> hdl/gnce_pkg.sv
// Shared constants, types and helper functions of the grid neighbor cell enumerator.
package gnce_pkg;

   // field widths
   localparam int DIM_W     = 7;
   localparam int IDX_W     = 18;
   localparam int MAX_DIM   = 64;
   localparam int Q_W       = $clog2(MAX_DIM);
   localparam int PLANE_W   = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int REM_W     = IDX_W + 1;
   localparam int CSR_IDX_W = 2;

   // neighborhood: 3 x 3 x 3 cells, the cell itself sits in the middle
   localparam int NB_SIDE   = 3;
   localparam int NB_COUNT  = NB_SIDE * NB_SIDE * NB_SIDE;
   localparam int NB_CENTER = NB_COUNT / 2;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_X        = 2'd0,
      CSR_DIM_Y        = 2'd1,
      CSR_DIM_Z        = 2'd2,
      CSR_FORWARD_ONLY = 2'd3
   } csr_index_type;

   // one cell handed from the front pipeline to the emitter
   typedef struct packed {
      logic [REM_W-1:0]    base;   // index of the (-1,-1,-1) corner, modulo 2^REM_W
      logic [DIM_W-1:0]    nx;
      logic [PLANE_W-1:0]  plane;
      logic [NB_COUNT-1:0] mask;   // neighbors still to send
      logic                empty;
   } item_type;

   // two restoring division steps
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [1:0]       q;
   } div2_type;

   // clamp a dimension register to MAX_DIM
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] res;
      res = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
      return res;
   endfunction

   // quotient bits sh and sh-1 of rem / dvs
   function automatic div2_type div_step2(input logic [REM_W-1:0]   rem,
                                          input logic [PLANE_W-1:0] dvs,
                                          input int               sh);
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      div2_type         res;
      r = rem;
      res.q = 2'b00;
      t = REM_W'(dvs) << sh;
      if (r >= t) begin
         r = r - t;
         res.q[1] = 1'b1;
      end
      t = REM_W'(dvs) << (sh - 1);
      if (r >= t) begin
         r = r - t;
         res.q[0] = 1'b1;
      end
      res.rem = r;
      return res;
   endfunction

endpackage

>>> hdl/gnce_emit.sv
// Neighbor emitter: sends one neighbor index per cycle through an output register, unless rsp_ready stalls it.
module gnce_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  gnce_pkg::item_type       in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [gnce_pkg::IDX_W-1:0] rsp_neighbor_index,
   output logic                     rsp_is_last,
   output logic                     rsp_is_empty
);

   logic                                em_valid_ff;
   gnce_pkg::item_type                  item_ff;
   logic                                rsp_valid_ff;
   logic [gnce_pkg::IDX_W-1:0]          nidx_ff;
   logic                                last_ff;
   logic                                empty_ff;

   logic                                out_load;
   logic                                step;
   logic                                found;
   logic [gnce_pkg::NB_COUNT-1:0]       sel_onehot;
   logic [gnce_pkg::NB_COUNT-1:0]       mask_rest;
   logic [1:0]                          sel_dx;
   logic [1:0]                          sel_dy;
   logic [1:0]                          sel_dz;
   logic [gnce_pkg::REM_W-1:0]          off_y;
   logic [gnce_pkg::REM_W-1:0]          off_z;
   logic [gnce_pkg::REM_W-1:0]          nidx_sum;
   logic                                last_in;

   // pick the first neighbor left in scan order (dz outer, dx inner)
   always_comb begin
      found      = 1'b0;
      sel_onehot = '0;
      sel_dx     = 2'd0;
      sel_dy     = 2'd0;
      sel_dz     = 2'd0;
      for (int kz = 0; kz < gnce_pkg::NB_SIDE; kz++) begin
         for (int ky = 0; ky < gnce_pkg::NB_SIDE; ky++) begin
            for (int kx = 0; kx < gnce_pkg::NB_SIDE; kx++) begin
               if (!found && item_ff.mask[kz * 9 + ky * 3 + kx]) begin
                  found = 1'b1;
                  sel_onehot[kz * 9 + ky * 3 + kx] = 1'b1;
                  sel_dx = 2'(kx);
                  sel_dy = 2'(ky);
                  sel_dz = 2'(kz);
               end
            end
         end
      end
   end

   // neighbor index = corner + kx + ky*nx + kz*plane
   always_comb begin
      case (sel_dy)
         2'd1:    off_y = gnce_pkg::REM_W'(item_ff.nx);
         2'd2:    off_y = gnce_pkg::REM_W'(item_ff.nx) << 1;
         default: off_y = '0;
      endcase
      case (sel_dz)
         2'd1:    off_z = gnce_pkg::REM_W'(item_ff.plane);
         2'd2:    off_z = gnce_pkg::REM_W'(item_ff.plane) << 1;
         default: off_z = '0;
      endcase
      nidx_sum  = item_ff.base + gnce_pkg::REM_W'(sel_dx) + off_y + off_z;
      mask_rest = item_ff.mask & ~sel_onehot;
      last_in   = item_ff.empty || (mask_rest == '0);
   end

   // handshake: output register frees when empty or taken
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign step      = em_valid_ff && out_load;
   assign in_ready  = !em_valid_ff || (out_load && last_in);

   // item holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
      end else if (in_ready) begin
         em_valid_ff <= in_valid;
      end
      if (in_ready) begin
         item_ff <= in_item;
      end else if (step) begin
         item_ff.mask <= mask_rest;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= em_valid_ff;
      end
      if (step) begin
         nidx_ff  <= item_ff.empty ? '0 : nidx_sum[gnce_pkg::IDX_W-1:0];
         last_ff  <= last_in;
         empty_ff <= item_ff.empty;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = nidx_ff;
   assign rsp_is_last        = last_ff;
   assign rsp_is_empty       = empty_ff;

endmodule

>>> hdl/grid_neighbor_cell_enumerator.sv
// Top level: configuration registers, coordinate pipeline and neighbor emitter.
//
// Takes a linear cell index of a 3-D grid of dim_x * dim_y * dim_z cells and
// returns the linear index of each in-grid neighbor (the cell itself included)
// in dz, dy, dx order, is_last set on the final one; forward_only drops those
// below the cell index, and an index outside the grid gives one empty, last
// result. Dimensions above 64 are clamped to 64. A cell passes a 9-stage
// pipeline (capture, two multiplies, then two restoring division steps per
// stage for z and for y). The emitter sends one result per cycle unless
// rsp_ready stalls it, and a cell holds the result channel until its 1 to 27
// results are sent; while it does, up to 9 further cells wait in the pipeline.
// Configuration must be written only while no transaction is in flight; the
// block does not enforce this. csr_ready is always high.
module grid_neighbor_cell_enumerator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gnce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gnce_pkg::DIM_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [gnce_pkg::IDX_W-1:0]     req_cell_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gnce_pkg::IDX_W-1:0]     rsp_neighbor_index,
   output logic                           rsp_is_last,
   output logic                           rsp_is_empty
);

   localparam int STAGES = 9;

   typedef struct packed {
      logic [gnce_pkg::IDX_W-1:0]   c;
      logic [gnce_pkg::DIM_W-1:0]   nx;
      logic [gnce_pkg::DIM_W-1:0]   ny;
      logic [gnce_pkg::DIM_W-1:0]   nz;
      logic                         fwd;
      logic [gnce_pkg::PLANE_W-1:0] plane;
      logic [gnce_pkg::REM_W-1:0]   total;
      logic [gnce_pkg::REM_W-1:0]   base;
      logic [gnce_pkg::REM_W-1:0]   rem;
      logic [gnce_pkg::Q_W-1:0]     z;
      logic [gnce_pkg::Q_W-1:0]     y;
      logic                         empty;
   } stage_type;

   logic [gnce_pkg::DIM_W-1:0] dim_x_ff;
   logic [gnce_pkg::DIM_W-1:0] dim_y_ff;
   logic [gnce_pkg::DIM_W-1:0] dim_z_ff;
   logic                       fwd_ff;

   stage_type                  st_ff [1:STAGES];
   stage_type                  st_in [1:STAGES];
   logic [STAGES:1]            v_ff;
   logic [STAGES:1]            v_in;
   logic                       pipe_adv;
   logic                       em_ready;
   gnce_pkg::item_type         em_item;
   gnce_pkg::div2_type         d4;
   gnce_pkg::div2_type         d5;
   gnce_pkg::div2_type         d6;
   gnce_pkg::div2_type         d7;
   gnce_pkg::div2_type         d8;
   gnce_pkg::div2_type         d9;
   logic [2:0]                 x_ok;
   logic [2:0]                 y_ok;
   logic [2:0]                 z_ok;
   logic [gnce_pkg::Q_W-1:0]   x_last;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= gnce_pkg::DIM_W'(1);
         dim_y_ff <= gnce_pkg::DIM_W'(1);
         dim_z_ff <= gnce_pkg::DIM_W'(1);
         fwd_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (gnce_pkg::csr_index_type'(csr_index))
            gnce_pkg::CSR_DIM_X:        dim_x_ff <= csr_wdata;
            gnce_pkg::CSR_DIM_Y:        dim_y_ff <= csr_wdata;
            gnce_pkg::CSR_DIM_Z:        dim_z_ff <= csr_wdata;
            gnce_pkg::CSR_FORWARD_ONLY: fwd_ff   <= csr_wdata[0];
            default:                    ;
         endcase
      end
   end

   // pipeline stage logic
   always_comb begin
      // capture cell and clamped dimensions
      st_in[1]       = st_ff[1];
      st_in[1].c     = req_cell_index;
      st_in[1].nx    = gnce_pkg::sat_dim(dim_x_ff);
      st_in[1].ny    = gnce_pkg::sat_dim(dim_y_ff);
      st_in[1].nz    = gnce_pkg::sat_dim(dim_z_ff);
      st_in[1].fwd   = fwd_ff;

      // plane size
      st_in[2]       = st_ff[1];
      st_in[2].plane = {{(gnce_pkg::PLANE_W - gnce_pkg::DIM_W){1'b0}}, st_ff[1].nx}
                     * {{(gnce_pkg::PLANE_W - gnce_pkg::DIM_W){1'b0}}, st_ff[1].ny};

      // grid size
      st_in[3]       = st_ff[2];
      st_in[3].total = {{(gnce_pkg::REM_W - gnce_pkg::PLANE_W){1'b0}}, st_ff[2].plane}
                     * {{(gnce_pkg::REM_W - gnce_pkg::DIM_W){1'b0}}, st_ff[2].nz};

      // range check, corner index, z division top bits
      d4             = gnce_pkg::div_step2(gnce_pkg::REM_W'(st_ff[3].c), st_ff[3].plane,
                                           gnce_pkg::Q_W - 1);
      st_in[4]       = st_ff[3];
      st_in[4].empty = gnce_pkg::REM_W'(st_ff[3].c) >= st_ff[3].total;
      st_in[4].base  = gnce_pkg::REM_W'(st_ff[3].c) - gnce_pkg::REM_W'(st_ff[3].nx)
                     - gnce_pkg::REM_W'(st_ff[3].plane) - gnce_pkg::REM_W'(1);
      st_in[4].rem   = d4.rem;
      st_in[4].z[gnce_pkg::Q_W-1 -: 2] = d4.q;

      // z division middle bits
      d5             = gnce_pkg::div_step2(st_ff[4].rem, st_ff[4].plane, gnce_pkg::Q_W - 3);
      st_in[5]       = st_ff[4];
      st_in[5].rem   = d5.rem;
      st_in[5].z[gnce_pkg::Q_W-3 -: 2] = d5.q;

      // z division low bits
      d6             = gnce_pkg::div_step2(st_ff[5].rem, st_ff[5].plane, gnce_pkg::Q_W - 5);
      st_in[6]       = st_ff[5];
      st_in[6].rem   = d6.rem;
      st_in[6].z[gnce_pkg::Q_W-5 -: 2] = d6.q;

      // y division by nx, remainder ends as x
      d7             = gnce_pkg::div_step2(st_ff[6].rem, gnce_pkg::PLANE_W'(st_ff[6].nx),
                                           gnce_pkg::Q_W - 1);
      st_in[7]       = st_ff[6];
      st_in[7].rem   = d7.rem;
      st_in[7].y[gnce_pkg::Q_W-1 -: 2] = d7.q;

      d8             = gnce_pkg::div_step2(st_ff[7].rem, gnce_pkg::PLANE_W'(st_ff[7].nx),
                                           gnce_pkg::Q_W - 3);
      st_in[8]       = st_ff[7];
      st_in[8].rem   = d8.rem;
      st_in[8].y[gnce_pkg::Q_W-3 -: 2] = d8.q;

      d9             = gnce_pkg::div_step2(st_ff[8].rem, gnce_pkg::PLANE_W'(st_ff[8].nx),
                                           gnce_pkg::Q_W - 5);
      st_in[9]       = st_ff[8];
      st_in[9].rem   = d9.rem;
      st_in[9].y[gnce_pkg::Q_W-5 -: 2] = d9.q;
   end

   // neighbor mask from the coordinates of the last stage
   always_comb begin
      x_last  = st_ff[STAGES].rem[gnce_pkg::Q_W-1:0];
      x_ok[0] = x_last != '0;
      x_ok[1] = 1'b1;
      x_ok[2] = (gnce_pkg::DIM_W'(x_last) + gnce_pkg::DIM_W'(1)) < st_ff[STAGES].nx;
      y_ok[0] = st_ff[STAGES].y != '0;
      y_ok[1] = 1'b1;
      y_ok[2] = (gnce_pkg::DIM_W'(st_ff[STAGES].y) + gnce_pkg::DIM_W'(1)) < st_ff[STAGES].ny;
      z_ok[0] = st_ff[STAGES].z != '0;
      z_ok[1] = 1'b1;
      z_ok[2] = (gnce_pkg::DIM_W'(st_ff[STAGES].z) + gnce_pkg::DIM_W'(1)) < st_ff[STAGES].nz;

      em_item.base  = st_ff[STAGES].base;
      em_item.nx    = st_ff[STAGES].nx;
      em_item.plane = st_ff[STAGES].plane;
      em_item.empty = st_ff[STAGES].empty;
      em_item.mask  = '0;
      for (int kz = 0; kz < gnce_pkg::NB_SIDE; kz++) begin
         for (int ky = 0; ky < gnce_pkg::NB_SIDE; ky++) begin
            for (int kx = 0; kx < gnce_pkg::NB_SIDE; kx++) begin
               // in-grid neighbors are ordered like their linear index
               em_item.mask[kz * 9 + ky * 3 + kx] = z_ok[kz] && y_ok[ky] && x_ok[kx]
                  && (!st_ff[STAGES].fwd || (kz * 9 + ky * 3 + kx >= gnce_pkg::NB_CENTER));
            end
         end
      end
   end

   // whole pipeline moves together unless the emitter holds the last stage
   assign pipe_adv  = !v_ff[STAGES] || em_ready;
   assign req_ready = pipe_adv;
   assign v_in      = {v_ff[STAGES-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (pipe_adv) begin
         v_ff <= v_in;
      end
      if (pipe_adv) begin
         for (int s = 1; s <= STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   gnce_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (v_ff[STAGES]),
      .in_ready           (em_ready),
      .in_item            (em_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_empty       (rsp_is_empty)
   );

`ifndef SYNTHESIS
   // an empty transaction is always the only and last one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_is_last)
      else $error("empty result without last flag");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_neighbor_index == '0)
      else $error("empty result carries a neighbor index");

   // the cell itself lies in the grid, so division must leave its own bit set
   a_self_bit: assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES] && !em_item.empty |-> em_item.mask[gnce_pkg::NB_CENTER])
      else $error("coordinate split put the cell outside the grid");

   // a stall freezes the pipeline occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_adv |=> $stable(v_ff))
      else $error("pipeline moved during a stall");
`endif

endmodule
